// ===== sv/tsa_pkg.sv =====
// Shared types, codes, constants and helpers of the task slot token arbiter.
package tsa_pkg;

	// Default sizes
	localparam int KINDS_DEF = 4;
	localparam int DEPTH_DEF = 16;

	// Grants per arbitrate item and the result buffer that holds them
	localparam int GRANT_CAP = 16;
	localparam int RBW       = $clog2(GRANT_CAP);
	localparam int GCW       = $clog2(GRANT_CAP + 1);

	// Ordering key: {arrival, user, sequence, round, kind, id}
	localparam int TU_W  = 64;
	localparam int ORD_W = 42;
	localparam int KEY_W = TU_W + ORD_W + 16;

	// APB register map
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_SLOT  = 3'd0;
	localparam logic [2:0] REG_QLIM  = 3'd1;
	localparam logic [2:0] REG_WGT   = 3'd2;
	localparam logic [2:0] REG_POOL  = 3'd3;
	localparam logic [2:0] REG_RLIM  = 3'd4;
	localparam logic [2:0] REG_AGING = 3'd5;

	// Register reset values
	localparam logic [31:0] SLOT_RST  = 32'h0101_0101;
	localparam logic [15:0] QLIM_RST  = 16'h4444;
	localparam logic [31:0] WGT_RST   = 32'h0101_0101;
	localparam logic [15:0] POOL_RST  = 16'd256;
	localparam logic [4:0]  RLIM_RST  = 5'd16;
	localparam logic [31:0] AGING_RST = 32'd0;

	// Item function codes
	localparam logic [1:0] FN_ENQ  = 2'd0;
	localparam logic [1:0] FN_ARB  = 2'd1;
	localparam logic [1:0] FN_MARK = 2'd2;
	localparam logic [1:0] FN_REL  = 2'd3;

	// Result status codes
	localparam logic [1:0] RS_OK   = 2'd0;
	localparam logic [1:0] RS_FULL = 2'd1;
	localparam logic [1:0] RS_BAD  = 2'd2;

	typedef enum logic [1:0] {
		ST_WAIT, ST_QUEUED, ST_RESERVED, ST_RUNNING
	} ent_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_SCAN_FIND, OP_ENQ_DEC, OP_ADMIT_CLR, OP_SCAN_WAIT,
		OP_ADMIT_DO, OP_MARK, OP_RELEASE, OP_RESV_CHECK, OP_HEAD_CLR, OP_SCAN_HEAD,
		OP_AGE_STEP, OP_AGE_DEC, OP_RR_STEP, OP_RR_DEC, OP_GRANT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       enq_ok;
		logic       admit_room;
		logic       admit_found;
		logic       rel_ok;
		logic       resv_active;
		logic       resv_go;
		logic       aging_on;
		logic       age_grant;
		logic       age_block;
		logic       rr_win;
		logic       full;
		logic       last;
	} dp_flags_t;

	typedef struct packed {
		logic [31:0] slot_counts;
		logic [15:0] queue_limits;
		logic [31:0] weight_set;
		logic [15:0] token_pool;
		logic [4:0]  registry_limit;
		logic [31:0] aging_threshold;
		logic        slot_load;
		logic        pool_load;
		logic [31:0] wdata;
	} cfg_t;

	// 8-bit field of kind k; kinds past four read zero
	function automatic logic [7:0] field8(input logic [31:0] r, input int k);
		logic [7:0] v;
		v = '0;
		if (k < 4) v = r[8*k +: 8];
		return v;
	endfunction

	// 4-bit queue limit of kind k; kinds past four read zero
	function automatic logic [3:0] field4(input logic [15:0] r, input int k);
		logic [3:0] v;
		v = '0;
		if (k < 4) v = r[4*k +: 4];
		return v;
	endfunction

endpackage

// ===== sv/tsa_cfg.sv =====
// APB configuration registers of the task slot token arbiter.
module tsa_cfg import tsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [31:0] slot_q;
	logic [15:0] qlim_q;
	logic [31:0] wgt_q;
	logic [15:0] pool_q;
	logic [4:0]  rlim_q;
	logic [31:0] aging_q;
	logic        wr;
	logic [2:0]  ridx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign ridx   = paddr[ADDR_W-1:2];

	// Write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= SLOT_RST;
			qlim_q  <= QLIM_RST;
			wgt_q   <= WGT_RST;
			pool_q  <= POOL_RST;
			rlim_q  <= RLIM_RST;
			aging_q <= AGING_RST;
		end else if (wr) begin
			case (ridx)
				REG_SLOT:  slot_q  <= pwdata;
				REG_QLIM:  qlim_q  <= pwdata[15:0];
				REG_WGT:   wgt_q   <= pwdata;
				REG_POOL:  pool_q  <= pwdata[15:0];
				REG_RLIM:  rlim_q  <= pwdata[4:0];
				REG_AGING: aging_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (ridx)
			REG_SLOT:  prdata = slot_q;
			REG_QLIM:  prdata = {16'd0, qlim_q};
			REG_WGT:   prdata = wgt_q;
			REG_POOL:  prdata = {16'd0, pool_q};
			REG_RLIM:  prdata = {27'd0, rlim_q};
			REG_AGING: prdata = aging_q;
			default:   prdata = '0;
		endcase
	end

	// Reload strobes act at the write edge itself
	always_comb begin
		cfg.slot_counts     = slot_q;
		cfg.queue_limits    = qlim_q;
		cfg.weight_set      = wgt_q;
		cfg.token_pool      = pool_q;
		cfg.registry_limit  = rlim_q;
		cfg.aging_threshold = aging_q;
		cfg.slot_load       = wr && (ridx == REG_SLOT);
		cfg.pool_load       = wr && (ridx == REG_POOL);
		cfg.wdata           = pwdata;
	end

endmodule

// ===== sv/tsa_dp.sv =====
// Datapath: task registry, kind queues, slot and token pools, round robin scores.
module tsa_dp import tsa_pkg::*; #(
	parameter int KINDS          = KINDS_DEF,
	parameter int REGISTRY_DEPTH = DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dp_cmd_t                           cmd,
	input  logic [$clog2(REGISTRY_DEPTH)-1:0] scan_idx,
	input  logic [$clog2(KINDS)-1:0]          kind_idx,
	input  logic [RBW-1:0]                    res_idx,
	input  cfg_t                              cfg,
	input  logic [1:0]                        func,
	input  logic [15:0]                       task_id,
	input  logic [1:0]                        task_kind,
	input  logic [15:0]                       tokens_needed,
	input  logic [47:0]                       arrival_time,
	input  logic [15:0]                       user_number,
	input  logic [31:0]                       task_sequence,
	input  logic [7:0]                        repair_round,
	input  logic [47:0]                       now_time,
	output dp_flags_t                         flags,
	output logic [1:0]                        status,
	output logic                              grant_valid,
	output logic [15:0]                       granted_id,
	output logic                              reservation_held,
	output logic [15:0]                       tokens_free
);

	localparam int IW = $clog2(REGISTRY_DEPTH);
	localparam int KW = $clog2(KINDS);
	localparam int CW = $clog2(REGISTRY_DEPTH + 1);
	localparam int LW = (CW > 5) ? CW : 5;
	localparam int SW = 8 + KW;

	// Registry
	logic             ent_valid_q [REGISTRY_DEPTH];
	ent_state_t       ent_state_q [REGISTRY_DEPTH];
	logic [15:0]      ent_id_q    [REGISTRY_DEPTH];
	logic [15:0]      ent_tok_q   [REGISTRY_DEPTH];
	logic [TU_W-1:0]  ent_tu_q    [REGISTRY_DEPTH];
	logic [ORD_W-1:0] ent_ord_q   [REGISTRY_DEPTH];

	// Captured item
	logic [1:0]       func_q;
	logic [15:0]      id_q;
	logic [1:0]       kind_q;
	logic [15:0]      tok_q;
	logic [TU_W-1:0]  tu_q;
	logic [ORD_W-1:0] ord_q;
	logic [47:0]      now_q;
	logic [15:0]      find_id_q;

	// Find scan
	logic [CW-1:0]    used_q;
	logic             free_v_q;
	logic [IW-1:0]    free_idx_q;
	logic             f_v_q;
	logic [IW-1:0]    f_idx_q;
	ent_state_t       f_state_q;
	logic [15:0]      f_tok_q;
	logic [1:0]       f_kind_q;

	// Admission search
	logic [1:0]       akind_q;
	logic             wb_v_q;
	logic [IW-1:0]    wb_idx_q;
	logic [KEY_W-1:0] wb_key_q;

	// Queue heads
	logic             hd_v_q   [KINDS];
	logic [IW-1:0]    hd_idx_q [KINDS];
	logic [KEY_W-1:0] hd_key_q [KINDS];
	logic [15:0]      hd_tok_q [KINDS];

	// Aging and round robin selection
	logic             old_v_q;
	logic [KW-1:0]    old_kind_q;
	logic [KEY_W-1:0] old_key_q;
	logic             win_v_q;
	logic [KW-1:0]    win_q;
	logic [15:0]      win_score_q;
	logic [SW-1:0]    sum_q;

	// Pending grant
	logic [IW-1:0]    g_idx_q;
	logic [KW-1:0]    g_kind_q;
	logic [15:0]      g_tok_q;
	logic [15:0]      g_id_q;

	// Pools and scores
	logic [4:0]       qcnt_q  [KINDS];
	logic [7:0]       slots_q [KINDS];
	logic [15:0]      tokens_q;
	logic [15:0]      score_q [KINDS];
	logic             resv_q;
	logic [15:0]      resv_id_q;

	// Results
	logic [15:0]      rbuf_q [GRANT_CAP];
	logic [GCW-1:0]   nres_q;
	logic [1:0]       rstat_q;

	// Per-kind register fields
	logic [7:0]       wt     [KINDS];
	logic [3:0]       qlim   [KINDS];
	logic [7:0]       slot_w [KINDS];

	always_comb begin
		for (int k = 0; k < KINDS; k++) begin
			wt[k]     = field8(cfg.weight_set, k);
			qlim[k]   = field4(cfg.queue_limits, k);
			slot_w[k] = field8(cfg.wdata, k);
		end
	end

	// Entry under scan
	logic             e_valid;
	ent_state_t       e_state;
	logic [15:0]      e_id;
	logic [15:0]      e_tok;
	logic [KEY_W-1:0] e_key;
	logic [1:0]       e_kind2;

	assign e_valid = ent_valid_q[scan_idx];
	assign e_state = ent_state_q[scan_idx];
	assign e_id    = ent_id_q[scan_idx];
	assign e_tok   = ent_tok_q[scan_idx];
	assign e_key   = {ent_tu_q[scan_idx], ent_ord_q[scan_idx], ent_id_q[scan_idx]};
	assign e_kind2 = ent_ord_q[scan_idx][1:0];

	// Decisions
	logic [LW-1:0] lim;
	logic          enq_full;
	logic          enq_ok;
	logic [KW-1:0] ak;
	logic [KW-1:0] fk;
	logic          fk_ok;
	logic          admit_room;
	logic          rel_ok;
	logic          resv_go;
	logic          old_sat;
	logic [47:0]   arr;
	logic          overdue;
	logic [15:0]   nscore;
	logic          upd_find;
	logic          upd_free;
	logic          upd_wait;
	logic          upd_head [KINDS];
	logic          upd_old;
	logic          rr_elig;
	logic          rr_take;
	logic [16:0]   tok_sum;
	logic [GCW-1:0] nout;

	always_comb begin
		lim = (LW'(cfg.registry_limit) < LW'(REGISTRY_DEPTH)) ?
			LW'(cfg.registry_limit) : LW'(REGISTRY_DEPTH);
		enq_full   = (LW'(used_q) >= lim) || !free_v_q || f_v_q;
		enq_ok     = !enq_full && (32'(kind_q) < KINDS);
		ak         = KW'(akind_q);
		fk         = KW'(f_kind_q);
		fk_ok      = 32'(f_kind_q) < KINDS;
		admit_room = (32'(akind_q) < KINDS) && (qcnt_q[ak] < {1'b0, qlim[ak]});
		rel_ok     = f_v_q && ((f_state_q == ST_RESERVED) || (f_state_q == ST_RUNNING));
		resv_go    = f_v_q && (f_state_q == ST_QUEUED) && fk_ok &&
			(slots_q[fk] != 8'd0) && (f_tok_q <= tokens_q);
		old_sat    = (slots_q[old_kind_q] != 8'd0) && (hd_tok_q[old_kind_q] <= tokens_q);
		arr        = hd_key_q[kind_idx][KEY_W-1 -: 48];
		overdue    = hd_v_q[kind_idx] && (now_q >= arr) &&
			((now_q - arr) >= {16'd0, cfg.aging_threshold});
		nscore     = score_q[kind_idx] + {8'd0, wt[kind_idx]};
		upd_find   = (cmd.op == OP_SCAN_FIND) && e_valid && (e_id == find_id_q) && !f_v_q;
		upd_free   = (cmd.op == OP_SCAN_FIND) && !e_valid && !free_v_q;
		upd_wait   = (cmd.op == OP_SCAN_WAIT) && e_valid && (e_state == ST_WAIT) &&
			(e_kind2 == akind_q) && (!wb_v_q || (e_key < wb_key_q));
		for (int k = 0; k < KINDS; k++) begin
			upd_head[k] = (cmd.op == OP_SCAN_HEAD) && e_valid && (e_state == ST_QUEUED) &&
				(32'(e_kind2) == k) && (!hd_v_q[k] || (e_key < hd_key_q[k]));
		end
		upd_old    = (cmd.op == OP_AGE_STEP) && overdue &&
			(!old_v_q || (hd_key_q[kind_idx] < old_key_q));
		rr_elig    = (cmd.op == OP_RR_STEP) && hd_v_q[kind_idx] &&
			(slots_q[kind_idx] != 8'd0) && (hd_tok_q[kind_idx] <= tokens_q);
		rr_take    = rr_elig && (!win_v_q || ($signed(nscore) > $signed(win_score_q)));
		tok_sum    = {1'b0, tokens_q} + {1'b0, f_tok_q};
		nout       = (nres_q == '0) ? GCW'(1) : nres_q;
	end

	// Control state: valid bits, pools, scores, reservation, search flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REGISTRY_DEPTH; i++) ent_valid_q[i] <= 1'b0;
			for (int k = 0; k < KINDS; k++) begin
				qcnt_q[k]  <= '0;
				slots_q[k] <= field8(SLOT_RST, k);
				score_q[k] <= '0;
				hd_v_q[k]  <= 1'b0;
			end
			tokens_q  <= POOL_RST;
			resv_q    <= 1'b0;
			resv_id_q <= '0;
			nres_q    <= '0;
			used_q    <= '0;
			free_v_q  <= 1'b0;
			f_v_q     <= 1'b0;
			wb_v_q    <= 1'b0;
			old_v_q   <= 1'b0;
			win_v_q   <= 1'b0;
		end else begin
			// Reload pools on register writes
			if (cfg.slot_load) begin
				for (int k = 0; k < KINDS; k++) slots_q[k] <= slot_w[k];
			end
			if (cfg.pool_load) tokens_q <= cfg.wdata[15:0];

			case (cmd.op)
				OP_LOAD: begin
					used_q   <= '0;
					free_v_q <= 1'b0;
					f_v_q    <= 1'b0;
					nres_q   <= '0;
				end
				OP_SCAN_FIND: begin
					if (e_valid) used_q <= used_q + CW'(1);
					if (upd_find) f_v_q <= 1'b1;
					if (upd_free) free_v_q <= 1'b1;
				end
				OP_ENQ_DEC: begin
					if (enq_ok) ent_valid_q[free_idx_q] <= 1'b1;
				end
				OP_ADMIT_CLR: wb_v_q <= 1'b0;
				OP_SCAN_WAIT: begin
					if (upd_wait) wb_v_q <= 1'b1;
				end
				OP_ADMIT_DO: begin
					if (wb_v_q) qcnt_q[ak] <= qcnt_q[ak] + 5'd1;
				end
				OP_RELEASE: begin
					if (rel_ok) begin
						if (fk_ok && (slots_q[fk] != 8'hFF)) slots_q[fk] <= slots_q[fk] + 8'd1;
						tokens_q <= tok_sum[16] ? 16'hFFFF : tok_sum[15:0];
						ent_valid_q[f_idx_q] <= 1'b0;
					end
				end
				OP_RESV_CHECK: begin
					if (resv_go) begin
						resv_q    <= 1'b0;
						resv_id_q <= '0;
					end
				end
				OP_HEAD_CLR: begin
					for (int k = 0; k < KINDS; k++) hd_v_q[k] <= 1'b0;
					old_v_q <= 1'b0;
					win_v_q <= 1'b0;
				end
				OP_SCAN_HEAD: begin
					for (int k = 0; k < KINDS; k++) begin
						if (upd_head[k]) hd_v_q[k] <= 1'b1;
					end
				end
				OP_AGE_STEP: begin
					if (upd_old) old_v_q <= 1'b1;
				end
				OP_AGE_DEC: begin
					if (old_v_q && !old_sat) begin
						resv_q    <= 1'b1;
						resv_id_q <= old_key_q[15:0];
					end
				end
				OP_RR_STEP: begin
					if (rr_elig) score_q[kind_idx] <= nscore;
					if (rr_take) win_v_q <= 1'b1;
				end
				OP_RR_DEC: begin
					if (win_v_q) score_q[win_q] <= score_q[win_q] - 16'(sum_q);
				end
				OP_GRANT: begin
					if (qcnt_q[g_kind_q] != 5'd0) qcnt_q[g_kind_q] <= qcnt_q[g_kind_q] - 5'd1;
					slots_q[g_kind_q] <= slots_q[g_kind_q] - 8'd1;
					tokens_q <= tokens_q - g_tok_q;
					nres_q   <= nres_q + GCW'(1);
				end
				default: ;
			endcase
		end
	end

	// Payload: entry fields, captures, pending grant, result buffer
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				func_q    <= func;
				id_q      <= task_id;
				kind_q    <= task_kind;
				tok_q     <= tokens_needed;
				tu_q      <= {arrival_time, user_number};
				ord_q     <= {task_sequence, repair_round, task_kind};
				now_q     <= now_time;
				akind_q   <= task_kind;
				rstat_q   <= RS_OK;
				find_id_q <= (func == FN_ARB) ? resv_id_q : task_id;
			end
			OP_SCAN_FIND: begin
				if (upd_find) begin
					f_idx_q   <= scan_idx;
					f_state_q <= e_state;
					f_tok_q   <= e_tok;
					f_kind_q  <= e_kind2;
				end
				if (upd_free) free_idx_q <= scan_idx;
			end
			OP_ENQ_DEC: begin
				if (enq_full) begin
					rstat_q <= RS_FULL;
				end else if (!enq_ok) begin
					rstat_q <= RS_BAD;
				end else begin
					ent_state_q[free_idx_q] <= ST_WAIT;
					ent_id_q[free_idx_q]    <= id_q;
					ent_tok_q[free_idx_q]   <= tok_q;
					ent_tu_q[free_idx_q]    <= tu_q;
					ent_ord_q[free_idx_q]   <= ord_q;
				end
			end
			OP_SCAN_WAIT: begin
				if (upd_wait) begin
					wb_idx_q <= scan_idx;
					wb_key_q <= e_key;
				end
			end
			OP_ADMIT_DO: begin
				if (wb_v_q) ent_state_q[wb_idx_q] <= ST_QUEUED;
			end
			OP_MARK: begin
				if (f_v_q && (f_state_q == ST_RESERVED)) ent_state_q[f_idx_q] <= ST_RUNNING;
				else rstat_q <= RS_BAD;
			end
			OP_RELEASE: begin
				if (rel_ok) akind_q <= f_kind_q;
				else rstat_q <= RS_BAD;
			end
			OP_RESV_CHECK: begin
				g_idx_q  <= f_idx_q;
				g_kind_q <= fk;
				g_tok_q  <= f_tok_q;
				g_id_q   <= find_id_q;
			end
			OP_HEAD_CLR: sum_q <= '0;
			OP_SCAN_HEAD: begin
				for (int k = 0; k < KINDS; k++) begin
					if (upd_head[k]) begin
						hd_idx_q[k] <= scan_idx;
						hd_key_q[k] <= e_key;
						hd_tok_q[k] <= e_tok;
					end
				end
			end
			OP_AGE_STEP: begin
				if (upd_old) begin
					old_kind_q <= kind_idx;
					old_key_q  <= hd_key_q[kind_idx];
				end
			end
			OP_AGE_DEC: begin
				g_idx_q  <= hd_idx_q[old_kind_q];
				g_kind_q <= old_kind_q;
				g_tok_q  <= hd_tok_q[old_kind_q];
				g_id_q   <= old_key_q[15:0];
			end
			OP_RR_STEP: begin
				if (rr_elig) sum_q <= sum_q + SW'(wt[kind_idx]);
				if (rr_take) begin
					win_q       <= kind_idx;
					win_score_q <= nscore;
				end
			end
			OP_RR_DEC: begin
				g_idx_q  <= hd_idx_q[win_q];
				g_kind_q <= win_q;
				g_tok_q  <= hd_tok_q[win_q];
				g_id_q   <= hd_key_q[win_q][15:0];
			end
			OP_GRANT: begin
				ent_state_q[g_idx_q]     <= ST_RESERVED;
				rbuf_q[nres_q[RBW-1:0]] <= g_id_q;
			end
			default: ;
		endcase
	end

	// Status toward the controller
	always_comb begin
		flags.func        = func_q;
		flags.enq_ok      = enq_ok;
		flags.admit_room  = admit_room;
		flags.admit_found = wb_v_q;
		flags.rel_ok      = rel_ok;
		flags.resv_active = resv_q;
		flags.resv_go     = resv_go;
		flags.aging_on    = cfg.aging_threshold != 32'd0;
		flags.age_grant   = old_v_q && old_sat;
		flags.age_block   = old_v_q && !old_sat;
		flags.rr_win      = win_v_q;
		flags.full        = nres_q == GCW'(GRANT_CAP);
		flags.last        = {1'b0, res_idx} == (nout - GCW'(1));
	end

	// Result fields
	assign status           = rstat_q;
	assign grant_valid      = nres_q != '0;
	assign granted_id       = grant_valid ? rbuf_q[res_idx] : 16'd0;
	assign reservation_held = resv_q;
	assign tokens_free      = tokens_q;

endmodule

// ===== sv/tsa_ctrl.sv =====
// Controller: sequences registry scans, admission, arbitration and result delivery.
module tsa_ctrl import tsa_pkg::*; #(
	parameter int KINDS          = KINDS_DEF,
	parameter int REGISTRY_DEPTH = DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	output logic                              out_valid,
	input  logic                              out_ready,
	input  dp_flags_t                         flags,
	output dp_cmd_t                           cmd,
	output logic [$clog2(REGISTRY_DEPTH)-1:0] scan_idx,
	output logic [$clog2(KINDS)-1:0]          kind_idx,
	output logic [RBW-1:0]                    res_idx
);

	localparam int IW = $clog2(REGISTRY_DEPTH);
	localparam int KW = $clog2(KINDS);
	localparam logic [IW-1:0] ILAST = IW'(REGISTRY_DEPTH - 1);
	localparam logic [KW-1:0] KLAST = KW'(KINDS - 1);

	typedef enum logic [4:0] {
		S_IDLE, S_FIND, S_ENQ, S_ACHK, S_WSCAN, S_ADO, S_MARK, S_REL, S_RESV,
		S_GRANT, S_HCLR, S_HSCAN, S_AGE, S_ADEC, S_RR, S_RDEC, S_EMIT
	} state_t;

	state_t        state_q;
	logic [IW-1:0] idx_q;
	logic [KW-1:0] kidx_q;
	logic [RBW-1:0] ridx_q;

	assign scan_idx  = idx_q;
	assign kind_idx  = kidx_q;
	assign res_idx   = ridx_q;
	assign in_ready  = state_q == S_IDLE;
	assign out_valid = state_q == S_EMIT;

	// Command for the datapath
	always_comb begin
		case (state_q)
			S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
			S_FIND:  cmd.op = OP_SCAN_FIND;
			S_ENQ:   cmd.op = OP_ENQ_DEC;
			S_ACHK:  cmd.op = OP_ADMIT_CLR;
			S_WSCAN: cmd.op = OP_SCAN_WAIT;
			S_ADO:   cmd.op = OP_ADMIT_DO;
			S_MARK:  cmd.op = OP_MARK;
			S_REL:   cmd.op = OP_RELEASE;
			S_RESV:  cmd.op = OP_RESV_CHECK;
			S_GRANT: cmd.op = OP_GRANT;
			S_HCLR:  cmd.op = OP_HEAD_CLR;
			S_HSCAN: cmd.op = OP_SCAN_HEAD;
			S_AGE:   cmd.op = OP_AGE_STEP;
			S_ADEC:  cmd.op = OP_AGE_DEC;
			S_RR:    cmd.op = OP_RR_STEP;
			S_RDEC:  cmd.op = OP_RR_DEC;
			default: cmd.op = OP_NONE;
		endcase
	end

	// Sequence state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			kidx_q  <= '0;
			ridx_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					idx_q  <= '0;
					ridx_q <= '0;
					if (in_valid) state_q <= S_FIND;
				end
				S_FIND: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q == ILAST) begin
						idx_q <= '0;
						case (flags.func)
							FN_ENQ:  state_q <= S_ENQ;
							FN_MARK: state_q <= S_MARK;
							FN_REL:  state_q <= S_REL;
							default: state_q <= flags.resv_active ? S_RESV : S_HCLR;
						endcase
					end
				end
				S_ENQ:  state_q <= flags.enq_ok ? S_ACHK : S_EMIT;
				S_ACHK: begin
					idx_q   <= '0;
					state_q <= flags.admit_room ? S_WSCAN : S_EMIT;
				end
				S_WSCAN: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q == ILAST) begin
						idx_q   <= '0;
						state_q <= S_ADO;
					end
				end
				// Release keeps admitting while the queue has room
				S_ADO: state_q <= (flags.admit_found && (flags.func == FN_REL)) ? S_ACHK : S_EMIT;
				S_MARK: state_q <= S_EMIT;
				S_REL:  state_q <= flags.rel_ok ? S_ACHK : S_EMIT;
				S_RESV: state_q <= flags.resv_go ? S_GRANT : S_EMIT;
				S_GRANT: state_q <= S_HCLR;
				S_HCLR: begin
					idx_q   <= '0;
					state_q <= flags.full ? S_EMIT : S_HSCAN;
				end
				S_HSCAN: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q == ILAST) begin
						idx_q   <= '0;
						kidx_q  <= '0;
						state_q <= flags.aging_on ? S_AGE : S_RR;
					end
				end
				S_AGE: begin
					kidx_q <= kidx_q + KW'(1);
					if (kidx_q == KLAST) begin
						kidx_q  <= '0;
						state_q <= S_ADEC;
					end
				end
				S_ADEC: begin
					kidx_q <= '0;
					if (flags.age_grant) state_q <= S_GRANT;
					else if (flags.age_block) state_q <= S_EMIT;
					else state_q <= S_RR;
				end
				S_RR: begin
					kidx_q <= kidx_q + KW'(1);
					if (kidx_q == KLAST) begin
						kidx_q  <= '0;
						state_q <= S_RDEC;
					end
				end
				S_RDEC: state_q <= flags.rr_win ? S_GRANT : S_EMIT;
				S_EMIT: begin
					if (out_ready) begin
						if (flags.last) state_q <= S_IDLE;
						else ridx_q <= ridx_q + RBW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/task_slot_token_arbiter_top.sv =====
// Top level of the task slot token arbiter: configuration port, controller, datapath.
//
//   channel  signals                                        direction
//   in       in_valid/in_ready + func..now_time             item in
//   out      out_valid/out_ready + status..tokens_free      results out
//   apb      psel/penable/pwrite/paddr/pwdata/prdata/pready register access
//
// One item at a time. Every item starts with a registry scan.
// An accepted enqueue adds an admission pass with its own registry scan; release adds one such
// pass per admitted task. Arbitrate runs a head scan and a round robin pass per grant (with aging
// on, an aging pass comes first and may grant in its place), up to 16 grants.
// Results are delivered after the work, one per cycle while out_ready is high.
// Reset is asynchronous; the registry starts empty and needs no clearing pass.
module task_slot_token_arbiter_top import tsa_pkg::*; #(
	parameter int KINDS          = KINDS_DEF,
	parameter int REGISTRY_DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        func,
	input  logic [15:0]       task_id,
	input  logic [1:0]        task_kind,
	input  logic [15:0]       tokens_needed,
	input  logic [47:0]       arrival_time,
	input  logic [15:0]       user_number,
	input  logic [31:0]       task_sequence,
	input  logic [7:0]        repair_round,
	input  logic [47:0]       now_time,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic              grant_valid,
	output logic [15:0]       granted_id,
	output logic              last,
	output logic              reservation_held,
	output logic [15:0]       tokens_free,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t                              cfg;
	dp_cmd_t                           cmd;
	dp_flags_t                         flags;
	logic [$clog2(REGISTRY_DEPTH)-1:0] scan_idx;
	logic [$clog2(KINDS)-1:0]          kind_idx;
	logic [RBW-1:0]                    res_idx;

	assign last = flags.last;

	tsa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tsa_ctrl #(
		.KINDS          (KINDS),
		.REGISTRY_DEPTH (REGISTRY_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.flags     (flags),
		.cmd       (cmd),
		.scan_idx  (scan_idx),
		.kind_idx  (kind_idx),
		.res_idx   (res_idx)
	);

	tsa_dp #(
		.KINDS          (KINDS),
		.REGISTRY_DEPTH (REGISTRY_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.scan_idx         (scan_idx),
		.kind_idx         (kind_idx),
		.res_idx          (res_idx),
		.cfg              (cfg),
		.func             (func),
		.task_id          (task_id),
		.task_kind        (task_kind),
		.tokens_needed    (tokens_needed),
		.arrival_time     (arrival_time),
		.user_number      (user_number),
		.task_sequence    (task_sequence),
		.repair_round     (repair_round),
		.now_time         (now_time),
		.flags            (flags),
		.status           (status),
		.grant_valid      (grant_valid),
		.granted_id       (granted_id),
		.reservation_held (reservation_held),
		.tokens_free      (tokens_free)
	);

endmodule

// ===== sv/tsa_checker.sv =====
// Port-level checks of the task slot token arbiter, bound to the top level.
module tsa_checker import tsa_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic        grant_valid,
	input logic [15:0] granted_id,
	input logic        last
);

	// Never take an item while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while results pending");

	// Drop ready once an item is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready stayed high after an item");

	// Return to idle after the final result
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=> !out_valid)
		else $error("results continued past the final one");

	// Grants always report success
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && grant_valid) |-> (status == RS_OK))
		else $error("grant with failing status");

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(granted_id) && $stable(last)))
		else $error("stalled result changed");

endmodule

bind task_slot_token_arbiter_top tsa_checker u_tsa_checker (.*);

// ===== test/tsa_grant_checker.sv =====
// Checker of the task slot token arbiter: predicts every result and compares it.
module tsa_grant_checker import tsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  func,
	input  logic [15:0] task_id,
	input  logic [1:0]  task_kind,
	input  logic [15:0] tokens_needed,
	input  logic [47:0] arrival_time,
	input  logic [15:0] user_number,
	input  logic [31:0] task_sequence,
	input  logic [7:0]  repair_round,
	input  logic [47:0] now_time,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic        grant_valid,
	input  logic [15:0] granted_id,
	input  logic        last,
	input  logic        reservation_held,
	input  logic [15:0] tokens_free,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending_count,
	output int          item_count,
	output int          result_count,
	output int          grant_count
);

	localparam int D = DEPTH_DEF;
	localparam int K = KINDS_DEF;

	typedef struct packed {
		logic [1:0]  status;
		logic        gv;
		logic [15:0] gid;
		logic        last;
		logic        resv;
		logic [15:0] tokens;
	} result_t;

	// Registers as last written
	logic [31:0] slot_reg, wgt_reg, aging_reg;
	logic [15:0] qlim_reg, pool_reg;
	logic [4:0]  rlim_reg;

	// Registry and scheduling state
	logic [63:0] m_tu  [D];
	logic [41:0] m_ord [D];
	logic        m_v   [D];
	ent_state_t  m_st  [D];
	logic [15:0] m_id  [D];
	logic [15:0] m_tok [D];
	logic [4:0]  qcnt  [K];
	logic [7:0]  slots [K];
	logic [15:0] score [K];
	logic [15:0] tok_av;
	logic        resv;
	logic [15:0] resv_id;

	result_t item_res[$];
	result_t due_results[$];

	function automatic int find_task(logic [15:0] id);
		for (int i = 0; i < D; i++)
			if (m_v[i] && m_id[i] == id) return i;
		return -1;
	endfunction

	function automatic bit key_less(int a, int b);
		if (m_tu[a] != m_tu[b]) return m_tu[a] < m_tu[b];
		if (m_ord[a] != m_ord[b]) return m_ord[a] < m_ord[b];
		return m_id[a] < m_id[b];
	endfunction

	function automatic int least_in(int k, ent_state_t st);
		int best;
		best = -1;
		for (int i = 0; i < D; i++) begin
			if (!m_v[i] || m_st[i] != st || int'(m_ord[i][1:0]) != k) continue;
			if (best < 0 || key_less(i, best)) best = i;
		end
		return best;
	endfunction

	function automatic bit fits(int i);
		return slots[m_ord[i][1:0]] > 0 && m_tok[i] <= tok_av;
	endfunction

	function automatic bit try_admit(int k);
		int c;
		if (qcnt[k] >= {1'b0, qlim_reg[4*k +: 4]}) return 0;
		c = least_in(k, ST_WAIT);
		if (c < 0) return 0;
		m_st[c] = ST_QUEUED;
		qcnt[k] = qcnt[k] + 1;
		return 1;
	endfunction

	function automatic void issue_grant(int i);
		int k;
		result_t r;
		k = m_ord[i][1:0];
		m_st[i] = ST_RESERVED;
		if (qcnt[k] > 0) qcnt[k] = qcnt[k] - 1;
		slots[k] = slots[k] - 1;
		tok_av = tok_av - m_tok[i];
		r = '0;
		r.status = RS_OK;
		r.gv = 1'b1;
		r.gid = m_id[i];
		item_res = {item_res, r};
	endfunction

	task automatic run_arbitration(logic [47:0] now);
		int t, oldest, h, winner;
		int heads[K];
		logic [31:0] sum;
		logic [7:0] w;
		logic [47:0] arr, age;
		bit done;
		done = 0;
		// Serve a held reservation first, or stay blocked
		if (resv) begin
			t = find_task(resv_id);
			if (t >= 0 && m_st[t] == ST_QUEUED && fits(t)) begin
				issue_grant(t);
				resv = 0;
				resv_id = '0;
			end else begin
				done = 1;
			end
		end
		while (!done && item_res.size() < GRANT_CAP) begin
			for (int k = 0; k < K; k++) heads[k] = least_in(k, ST_QUEUED);
			oldest = -1;
			// Pick the oldest overdue head
			if (aging_reg != 0) begin
				for (int k = 0; k < K; k++) begin
					h = heads[k];
					if (h < 0) continue;
					arr = m_tu[h][63:16];
					age = now >= arr ? now - arr : 48'd0;
					if (age >= 48'(aging_reg) && (oldest < 0 || key_less(h, oldest)))
						oldest = h;
				end
			end
			if (oldest >= 0) begin
				if (fits(oldest)) begin
					issue_grant(oldest);
				end else begin
					resv = 1;
					resv_id = m_id[oldest];
					done = 1;
				end
			end else begin
				// Smooth weighted round robin over eligible heads
				sum = '0;
				winner = -1;
				for (int k = 0; k < K; k++) begin
					h = heads[k];
					if (h >= 0 && slots[k] > 0 && m_tok[h] <= tok_av) begin
						w = wgt_reg[8*k +: 8];
						score[k] = score[k] + 16'(w);
						sum = sum + 32'(w);
						if (winner < 0 || $signed(score[k]) > $signed(score[winner]))
							winner = k;
					end
				end
				if (winner < 0) begin
					done = 1;
				end else begin
					score[winner] = score[winner] - sum[15:0];
					issue_grant(heads[winner]);
				end
			end
		end
	endtask

	task automatic predict_item();
		int used, fr, e, k;
		logic [4:0] lim;
		logic [16:0] t;
		result_t r;
		item_res.delete();
		r = '0;
		case (func)
			FN_ENQ: begin
				used = 0;
				fr = -1;
				for (int i = 0; i < D; i++) begin
					if (m_v[i]) used++;
					else if (fr < 0) fr = i;
				end
				lim = rlim_reg < D ? rlim_reg : 5'(D);
				if (used >= int'(lim) || fr < 0 || find_task(task_id) >= 0) begin
					r.status = RS_FULL;
				end else begin
					m_tu[fr]  = {arrival_time, user_number};
					m_ord[fr] = {task_sequence, repair_round, task_kind};
					m_v[fr]   = 1'b1;
					m_st[fr]  = ST_WAIT;
					m_id[fr]  = task_id;
					m_tok[fr] = tokens_needed;
					void'(try_admit(task_kind));
					r.status = RS_OK;
				end
				item_res = {item_res, r};
			end
			FN_ARB: begin
				run_arbitration(now_time);
				if (item_res.size() == 0) item_res = {item_res, r};
			end
			FN_MARK: begin
				e = find_task(task_id);
				r.status = RS_BAD;
				if (e >= 0 && m_st[e] == ST_RESERVED) begin
					m_st[e] = ST_RUNNING;
					r.status = RS_OK;
				end
				item_res = {item_res, r};
			end
			default: begin
				e = find_task(task_id);
				r.status = RS_BAD;
				if (e >= 0 && (m_st[e] == ST_RESERVED || m_st[e] == ST_RUNNING)) begin
					// Return slot and tokens, saturating, then refill the queue
					k = m_ord[e][1:0];
					if (slots[k] < 8'd255) slots[k] = slots[k] + 1;
					t = {1'b0, tok_av} + {1'b0, m_tok[e]};
					tok_av = t[16] ? 16'hFFFF : t[15:0];
					m_v[e] = 1'b0;
					while (try_admit(k)) ;
					r.status = RS_OK;
				end
				item_res = {item_res, r};
			end
		endcase
		// Stamp the after-item state and queue up the results
		for (int i = 0; i < item_res.size(); i++) begin
			r = item_res[i];
			r.resv = resv;
			r.tokens = tok_av;
			r.last = (i == item_res.size() - 1);
			if (r.gv) grant_count++;
			due_results = {due_results, r};
		end
	endtask

	task automatic apply_write(logic [2:0] idx, logic [31:0] v);
		case (idx)
			REG_SLOT: begin
				slot_reg = v;
				for (int k = 0; k < K; k++) slots[k] = v[8*k +: 8];
			end
			REG_QLIM: qlim_reg = v[15:0];
			REG_WGT:  wgt_reg = v;
			REG_POOL: begin
				pool_reg = v[15:0];
				tok_av = v[15:0];
			end
			REG_RLIM:  rlim_reg = v[4:0];
			REG_AGING: aging_reg = v;
			default: ;
		endcase
	endtask

	function automatic string res_str(result_t x);
		return $sformatf("st=%0d gv=%0d id=%0d last=%0d resv=%0d tok=%0d",
			x.status, x.gv, x.gid, x.last, x.resv, x.tokens);
	endfunction

	task automatic report_mismatch(string what, result_t got, result_t want);
		$display("mismatch (%s): got %s, want %s", what, res_str(got), res_str(want));
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		string what;
		if (!arst_n) begin
			slot_reg = SLOT_RST;
			qlim_reg = QLIM_RST;
			wgt_reg = WGT_RST;
			pool_reg = POOL_RST;
			rlim_reg = RLIM_RST;
			aging_reg = AGING_RST;
			for (int i = 0; i < D; i++) begin
				m_v[i] = 1'b0;
				m_st[i] = ST_WAIT;
			end
			for (int k = 0; k < K; k++) begin
				qcnt[k] = '0;
				slots[k] = SLOT_RST[8*k +: 8];
				score[k] = '0;
			end
			tok_av = POOL_RST;
			resv = 1'b0;
			resv_id = '0;
			due_results.delete();
			fail_count = 0;
			pending_count = 0;
			item_count = 0;
			result_count = 0;
			grant_count = 0;
		end else begin
			// Compare an accepted result with the oldest expectation
			if (out_valid && out_ready) begin
				result_count++;
				got = '{status, grant_valid, granted_id, last, reservation_held, tokens_free};
				if (due_results.size() == 0) begin
					report_mismatch("unexpected result", got, '0);
				end else begin
					want = due_results.pop_front();
					what = "";
					if (got.status != want.status) what = {what, " status"};
					if (got.gv != want.gv) what = {what, " grant_valid"};
					if (got.gid != want.gid) what = {what, " granted_id"};
					if (got.last != want.last) what = {what, " last"};
					if (got.resv != want.resv) what = {what, " reservation_held"};
					if (got.tokens != want.tokens) what = {what, " tokens_free"};
					if (what != "") report_mismatch(what, got, want);
				end
			end
			if (psel && penable && pwrite && pready) apply_write(paddr[4:2], pwdata);
			if (in_valid && in_ready) begin
				item_count++;
				predict_item();
			end
			pending_count = due_results.size();
		end
	end

endmodule

// ===== test/task_slot_token_arbiter_top_tb.sv =====
// Testbench top of the task slot token arbiter: stimulus, idling phases and verdict.
module task_slot_token_arbiter_top_tb import tsa_pkg::*;;

	localparam int LIMIT = 1_000_000;
	localparam int SETTLE = 600;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0]  func, task_kind, status;
	logic [15:0] task_id, tokens_needed, user_number, granted_id, tokens_free;
	logic [47:0] arrival_time, now_time;
	logic [31:0] task_sequence, pwdata, prdata;
	logic [7:0]  repair_round;
	logic grant_valid, last, reservation_held;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	int fail_count, pending_count, item_count, result_count, grant_count;
	int send_pct, stall_pct, cyc;

	task_slot_token_arbiter_top i_dut (.*);

	tsa_grant_checker i_chk (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog
	initial begin
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc > LIMIT) begin
				$display("timeout after %0d cycles", cyc);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Receiver stalls
	always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	// Drive one item and hold it until accepted; returns at the accepting edge or after a random idle gap
	task automatic send_item(logic [1:0] f, logic [15:0] id, logic [1:0] kind,
			logic [15:0] tok, logic [47:0] arr, logic [15:0] usr, logic [31:0] seq,
			logic [7:0] rnd, logic [47:0] now);
		in_valid <= 1'b1;
		func <= f;
		task_id <= id;
		task_kind <= kind;
		tokens_needed <= tok;
		arrival_time <= arr;
		user_number <= usr;
		task_sequence <= seq;
		repair_round <= rnd;
		now_time <= now;
		do @(posedge clk); while (!in_ready);
		if ($urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every result is in and the block is quiet
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_regs(logic [31:0] sc, logic [15:0] ql, logic [31:0] wg,
			logic [15:0] pl, logic [4:0] rl, logic [31:0] ag);
		cfg_write(REG_SLOT, sc);
		cfg_write(REG_QLIM, 32'(ql));
		cfg_write(REG_WGT, wg);
		cfg_write(REG_POOL, 32'(pl));
		cfg_write(REG_RLIM, 32'(rl));
		cfg_write(REG_AGING, ag);
	endtask

	// One random item: mostly small ids and ages so tasks meet again
	task automatic random_item();
		logic [1:0] f;
		logic [15:0] id, tok;
		logic [47:0] arr, now;
		int r;
		r = $urandom_range(0, 99);
		f = r < 38 ? FN_ENQ : r < 62 ? FN_ARB : r < 76 ? FN_MARK : FN_REL;
		id = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 23));
		tok = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40));
		arr = $urandom_range(0, 9) == 0 ? rand48() : 48'($urandom_range(0, 1000));
		now = $urandom_range(0, 9) == 0 ? rand48() : 48'($urandom_range(0, 2000));
		send_item(f, id, 2'($urandom), tok, arr, 16'($urandom), $urandom,
			8'($urandom), now);
	endtask

	initial begin
		in_valid = 1'b0;
		func = FN_ENQ;
		task_id = '0;
		task_kind = '0;
		tokens_needed = '0;
		arrival_time = '0;
		user_number = '0;
		task_sequence = '0;
		repair_round = '0;
		now_time = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		out_ready = 1'b0;
		send_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fill the registry and arbitrate over it, duplicates and wrong states
		cfg_write(REG_SLOT, 32'hFFFF_FFFF);
		cfg_write(REG_QLIM, 32'h0000_FFFF);
		for (int i = 0; i < 15; i++)
			send_item(FN_ENQ, 16'(i), 2'(i), 16'd0, 48'(i), 16'd0, 32'd0, 8'd0, 48'd0);
		send_item(FN_ENQ, 16'hFFFF, 2'd3, 16'hFFFF, '1, '1, '1, '1, '1);
		send_item(FN_ENQ, 16'd100, 2'd1, 16'd1, 48'd1, 16'd1, 32'd1, 8'd1, 48'd0);
		drain();
		cfg_write(REG_RLIM, 32'd0);
		send_item(FN_ENQ, 16'd0, 2'd0, 16'd0, 48'd0, 16'd0, 32'd0, 8'd0, 48'd0);
		send_item(FN_ARB, 16'd0, 2'd0, 16'd0, 48'd0, 16'd0, 32'd0, 8'd0, 48'd0);
		send_item(FN_MARK, 16'd0, 2'd0, 16'd0, 48'd0, 16'd0, 32'd0, 8'd0, 48'd0);
		send_item(FN_MARK, 16'd0, 2'd0, 16'd0, 48'd0, 16'd0, 32'd0, 8'd0, 48'd0);
		send_item(FN_MARK, 16'd777, 2'd0, 16'd0, 48'd0, 16'd0, 32'd0, 8'd0, 48'd0);
		send_item(FN_REL, 16'd0, 2'd0, 16'd0, 48'd0, 16'd0, 32'd0, 8'd0, 48'd0);
		send_item(FN_REL, 16'd0, 2'd0, 16'd0, 48'd0, 16'd0, 32'd0, 8'd0, 48'd0);
		drain();
		// Overdue head that cannot be served sets a reservation; head past now is not overdue
		cfg_write(REG_RLIM, 32'd16);
		cfg_write(REG_AGING, 32'd1);
		send_item(FN_ENQ, 16'd200, 2'd0, 16'hFFFF, 48'd0, 16'd5, 32'd5, 8'd5, 48'd0);
		send_item(FN_ARB, 16'd0, 2'd0, 16'd0, 48'd0, 16'd0, 32'd0, 8'd0, 48'd1000);
		send_item(FN_ARB, 16'd0, 2'd0, 16'd0, 48'd0, 16'd0, 32'd0, 8'd0, 48'd1000);
		drain();
		cfg_write(REG_POOL, 32'h0000_FFFF);
		send_item(FN_ARB, 16'd0, 2'd0, 16'd0, 48'd0, 16'd0, 32'd0, 8'd0, 48'd1000);
		drain();

		// Random phases, each with its own register setting and idling
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					send_pct = 0;
					stall_pct = 0;
					set_regs(32'h0202_0202, 16'h4444, 32'h0102_0304, 16'd256, 5'd16, 32'd0);
				end
				1: begin
					send_pct = 71;
					stall_pct = 0;
					set_regs(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 5'd31, 32'd50);
				end
				2: begin
					send_pct = 0;
					stall_pct = 71;
					set_regs(32'h0001_0203, 16'h1230, 32'h00FF_8001, 16'd60, 5'd6,
						32'hFFFF_FFFF);
				end
				default: begin
					send_pct = 25;
					stall_pct = 25;
					set_regs(32'h0303_0303, 16'h2121, 32'h0000_0000, 16'd0, 5'd10, 32'd1);
				end
			endcase
			repeat (38) random_item();
			drain();
		end

		$display("covered %0d items and %0d results with %0d grants", item_count,
			result_count, grant_count);
		$display("over four idling phases and five register settings");
		if (fail_count == 0 && pending_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
